// File: rtl/stras_pkg.sv
// Shared types and constants for the segment tree range add / range sum block.
// Used by stras_ctrl, stras_datapath and segment_tree_range_add_sum.
package stras_pkg;

    localparam int DATA_W = 64;
    localparam int CNT_W  = 11;
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // request kinds
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_BUILD = 2'd1,
        REQ_ADD   = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_START,
        OP_LOAD,
        OP_RD_CUR,
        OP_BUILD_WR,
        OP_ACC,
        OP_AP_SELF,
        OP_PUSH_WR,
        OP_AP_LEFT,
        OP_AP_RIGHT,
        OP_MUL0,
        OP_MUL1,
        OP_PSUM,
        OP_AP_WR,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_RD_LEFT,
        OP_RD_RIGHT,
        OP_FIN_WR,
        OP_POP,
        OP_OUT
    } dp_op_t;

    // datapath status seen by the controller
    typedef struct packed {
        req_t kind;
        logic range_ok;
        logic n_ok;
        logic is_leaf;
        logic covered;
        logic pend_nz;
        logic go_left;
        logic go_right;
        logic sp_zero;
        logic top_from_left;
        logic out_full;
        logic clr_done;
    } dp_status_t;

    // one tree node: pending add and node sum
    typedef struct packed {
        logic [DATA_W-1:0] pend;
        logic [DATA_W-1:0] sum;
    } node_word_t;

endpackage

// File: rtl/stras_ctrl.sv
// Controller state machine for the segment tree block: walks the tree with
// an explicit stack held in the datapath. Depends on stras_pkg.
module stras_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  stras_pkg::dp_status_t st,
    output stras_pkg::dp_op_t    op
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LOAD, S_ENTER, S_EVAL,
        S_PL_RD, S_PR_RD, S_AP_M0, S_AP_M1, S_AP_SUM, S_AP_WR,
        S_DESC_L, S_DESC_R, S_FIN, S_FIN1, S_FIN2, S_RET
    } state_t;

    typedef enum logic [1:0] {
        RET_SELF, RET_LEFT, RET_RIGHT
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and micro-operation
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        op         = stras_pkg::OP_NOP;
        case (state_reg)
            S_CLEAR: begin
                op = stras_pkg::OP_CLEAR;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op         = stras_pkg::OP_START;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (st.kind)
                    stras_pkg::REQ_LOAD:  state_next = S_LOAD;
                    stras_pkg::REQ_BUILD: state_next = st.n_ok ? S_ENTER : S_IDLE;
                    stras_pkg::REQ_ADD:   state_next = st.range_ok ? S_ENTER : S_IDLE;
                    default:              state_next = st.range_ok ? S_ENTER : S_RET;
                endcase
            end
            S_LOAD: begin
                op         = stras_pkg::OP_LOAD;
                state_next = S_IDLE;
            end
            S_ENTER: begin
                op         = stras_pkg::OP_RD_CUR;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (st.kind == stras_pkg::REQ_BUILD) begin
                    op         = stras_pkg::OP_BUILD_WR;
                    state_next = st.is_leaf ? S_RET : S_DESC_L;
                end else if (st.covered) begin
                    if (st.kind == stras_pkg::REQ_QUERY) begin
                        op         = stras_pkg::OP_ACC;
                        state_next = S_RET;
                    end else begin
                        op         = stras_pkg::OP_AP_SELF;
                        ret_next   = RET_SELF;
                        state_next = S_AP_M0;
                    end
                end else if (st.pend_nz) begin
                    op         = stras_pkg::OP_PUSH_WR;
                    state_next = S_PL_RD;
                end else begin
                    state_next = S_DESC_L;
                end
            end
            S_PL_RD: begin
                op         = stras_pkg::OP_AP_LEFT;
                ret_next   = RET_LEFT;
                state_next = S_AP_M0;
            end
            S_PR_RD: begin
                op         = stras_pkg::OP_AP_RIGHT;
                ret_next   = RET_RIGHT;
                state_next = S_AP_M0;
            end
            S_AP_M0: begin
                op         = stras_pkg::OP_MUL0;
                state_next = S_AP_M1;
            end
            S_AP_M1: begin
                op         = stras_pkg::OP_MUL1;
                state_next = S_AP_SUM;
            end
            S_AP_SUM: begin
                op         = stras_pkg::OP_PSUM;
                state_next = S_AP_WR;
            end
            S_AP_WR: begin
                op = stras_pkg::OP_AP_WR;
                case (ret_reg)
                    RET_SELF:  state_next = S_RET;
                    RET_LEFT:  state_next = S_PR_RD;
                    default:   state_next = S_DESC_L;
                endcase
            end
            S_DESC_L: begin
                if (st.kind == stras_pkg::REQ_BUILD || st.go_left) begin
                    op         = stras_pkg::OP_PUSH_L;
                    state_next = S_ENTER;
                end else begin
                    state_next = S_DESC_R;
                end
            end
            S_DESC_R: begin
                if (st.kind == stras_pkg::REQ_BUILD || st.go_right) begin
                    op         = stras_pkg::OP_PUSH_R;
                    state_next = S_ENTER;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (st.kind == stras_pkg::REQ_QUERY) begin
                    state_next = S_RET;
                end else begin
                    op         = stras_pkg::OP_RD_LEFT;
                    state_next = S_FIN1;
                end
            end
            S_FIN1: begin
                op         = stras_pkg::OP_RD_RIGHT;
                state_next = S_FIN2;
            end
            S_FIN2: begin
                op         = stras_pkg::OP_FIN_WR;
                state_next = S_RET;
            end
            S_RET: begin
                if (st.sp_zero) begin
                    if (st.kind == stras_pkg::REQ_QUERY) begin
                        if (!st.out_full) begin
                            op         = stras_pkg::OP_OUT;
                            state_next = S_IDLE;
                        end
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    op         = stras_pkg::OP_POP;
                    state_next = st.top_from_left ? S_DESC_R : S_FIN;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // state and return-point registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ret_reg   <= RET_SELF;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// File: rtl/stras_datapath.sv
// Datapath for the segment tree block: node and element memories, walk
// stack, split multiplier, accumulator and output register. Depends on stras_pkg.
module stras_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  stras_pkg::dp_op_t                  op,
    output stras_pkg::dp_status_t              st,
    input  logic                               cfg_wr_en,
    input  logic [stras_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic [1:0]                         s_req_type,
    input  logic [stras_pkg::CNT_W-1:0]        s_range_low,
    input  logic [stras_pkg::CNT_W-1:0]        s_range_high,
    input  logic signed [stras_pkg::DATA_W-1:0] s_value,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic signed [stras_pkg::DATA_W-1:0] m_range_sum
);

    localparam int DW     = stras_pkg::DATA_W;
    localparam int CW     = stras_pkg::CNT_W;
    localparam int IDX_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int AW     = (IDX_W > CW) ? IDX_W : CW;
    localparam int NODES  = 4 * MAX_ELEMENTS;
    localparam int NODE_W = $clog2(NODES);
    localparam int EA_W   = $clog2(MAX_ELEMENTS);
    localparam int STK_D  = $clog2(MAX_ELEMENTS) + 1;
    localparam int SPW    = $clog2(STK_D + 1);
    localparam int SIW    = $clog2(STK_D);
    localparam int PW     = 32 + IDX_W;

    // memories
    stras_pkg::node_word_t node_mem [NODES];
    logic [DW-1:0]         elem_mem [MAX_ELEMENTS];

    // walk stack (read only at the top)
    logic [NODE_W-1:0] stk_node [STK_D];
    logic [IDX_W-1:0]  stk_lo   [STK_D];
    logic [IDX_W-1:0]  stk_hi   [STK_D];
    logic              stk_left [STK_D];

    logic [CW-1:0]      cnt_reg;
    logic [SPW-1:0]     sp_reg;
    logic [NODE_W-1:0]  clr_cnt_reg;
    logic               out_valid_reg;
    stras_pkg::req_t    kind_reg;
    logic [AW-1:0]      a_reg, b_reg;
    logic [DW-1:0]      v_reg;
    logic [NODE_W-1:0]  cur_node_reg;
    logic [IDX_W-1:0]   cur_lo_reg, cur_hi_reg;
    stras_pkg::node_word_t rd_reg;
    logic [DW-1:0]      elem_rd_reg;
    logic [DW-1:0]      pend_reg, lsum_reg, acc_reg, out_sum_reg;
    logic [NODE_W-1:0]  ap_tgt_reg;
    logic [DW-1:0]      ap_add_reg;
    logic [IDX_W-1:0]   ap_len_reg;
    logic [PW-1:0]      p0_reg, p1_reg;
    logic [DW-1:0]      prod_reg;

    logic [AW-1:0]      cnt_ext, n_ext, lo_aw, hi_aw, mid_aw, load_idx;
    logic [IDX_W-1:0]   n, mid, len_self, len_left, len_right, leaf_idx;
    logic [IDX_W:0]     mid_sum;
    logic [NODE_W-1:0]  left_node, right_node;
    logic [SIW-1:0]     top_idx, push_idx;
    logic [SPW-1:0]     sp_dec;
    logic [EA_W-1:0]    load_addr, leaf_addr;
    logic               load_ok;

    logic               mem_we, mem_re;
    logic [NODE_W-1:0]  mem_addr;
    stras_pkg::node_word_t mem_wdata;

    // active element count, clamped to the tree size
    assign cnt_ext = AW'(cnt_reg);
    assign n_ext   = (cnt_ext > AW'(MAX_ELEMENTS)) ? AW'(MAX_ELEMENTS) : cnt_ext;
    assign n       = IDX_W'(n_ext);

    // current node geometry
    assign mid_sum    = (IDX_W + 1)'(cur_lo_reg) + (IDX_W + 1)'(cur_hi_reg);
    assign mid        = mid_sum[IDX_W:1];
    assign lo_aw      = AW'(cur_lo_reg);
    assign hi_aw      = AW'(cur_hi_reg);
    assign mid_aw     = AW'(mid);
    assign len_self   = IDX_W'(cur_hi_reg - cur_lo_reg + 1'b1);
    assign len_left   = IDX_W'(mid - cur_lo_reg + 1'b1);
    assign len_right  = IDX_W'(cur_hi_reg - mid);
    assign left_node  = {cur_node_reg[NODE_W-2:0], 1'b0};
    assign right_node = {cur_node_reg[NODE_W-2:0], 1'b1};

    // element addresses
    assign load_idx  = a_reg - 1'b1;
    assign load_addr = load_idx[EA_W-1:0];
    assign leaf_idx  = cur_lo_reg - 1'b1;
    assign leaf_addr = leaf_idx[EA_W-1:0];
    assign load_ok   = (a_reg != '0) && (a_reg <= AW'(n));

    // stack indexes
    assign sp_dec   = sp_reg - 1'b1;
    assign top_idx  = sp_dec[SIW-1:0];
    assign push_idx = sp_reg[SIW-1:0];

    // status to the controller
    always_comb begin
        st.kind          = kind_reg;
        st.n_ok          = (n != '0);
        st.range_ok      = (n != '0) && (a_reg != '0) && (a_reg <= b_reg)
                           && (b_reg <= AW'(n));
        st.is_leaf       = (cur_lo_reg == cur_hi_reg);
        st.covered       = (a_reg <= lo_aw) && (hi_aw <= b_reg);
        st.pend_nz       = (rd_reg.pend != '0);
        st.go_left       = (a_reg <= mid_aw);
        st.go_right      = (b_reg > mid_aw);
        st.sp_zero       = (sp_reg == '0);
        st.top_from_left = stk_left[top_idx];
        st.out_full      = out_valid_reg;
        st.clr_done      = (clr_cnt_reg == NODE_W'(NODES - 1));
    end

    // node memory port select
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = cur_node_reg;
        mem_wdata = '0;
        case (op)
            stras_pkg::OP_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            stras_pkg::OP_RD_CUR: mem_re = 1'b1;
            stras_pkg::OP_BUILD_WR: begin
                mem_we        = 1'b1;
                mem_wdata.sum = (cur_lo_reg == cur_hi_reg) ? elem_rd_reg : rd_reg.sum;
            end
            stras_pkg::OP_PUSH_WR: begin
                mem_we        = 1'b1;
                mem_wdata.sum = rd_reg.sum;
            end
            stras_pkg::OP_AP_LEFT, stras_pkg::OP_RD_LEFT: begin
                mem_re   = 1'b1;
                mem_addr = left_node;
            end
            stras_pkg::OP_AP_RIGHT, stras_pkg::OP_RD_RIGHT: begin
                mem_re   = 1'b1;
                mem_addr = right_node;
            end
            stras_pkg::OP_AP_WR: begin
                mem_we         = 1'b1;
                mem_addr       = ap_tgt_reg;
                mem_wdata.pend = rd_reg.pend + ap_add_reg;
                mem_wdata.sum  = rd_reg.sum + prod_reg;
            end
            stras_pkg::OP_FIN_WR: begin
                mem_we        = 1'b1;
                mem_wdata.sum = lsum_reg + rd_reg.sum;
            end
            default: ;
        endcase
    end

    // node memory: one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) node_mem[mem_addr] <= mem_wdata;
        if (mem_re) rd_reg <= node_mem[mem_addr];
    end

    // element store: cleared with the node memory, loaded, read for leaves
    always_ff @(posedge aclk) begin
        if (op == stras_pkg::OP_CLEAR && clr_cnt_reg < NODE_W'(MAX_ELEMENTS)) begin
            elem_mem[clr_cnt_reg[EA_W-1:0]] <= '0;
        end else if (op == stras_pkg::OP_LOAD && load_ok) begin
            elem_mem[load_addr] <= v_reg;
        end
        if (op == stras_pkg::OP_RD_CUR) elem_rd_reg <= elem_mem[leaf_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= stras_pkg::CNT_RESET;
            sp_reg        <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) cnt_reg <= cfg_wr_data;
            if (op == stras_pkg::OP_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            case (op)
                stras_pkg::OP_START:  sp_reg <= '0;
                stras_pkg::OP_PUSH_L,
                stras_pkg::OP_PUSH_R: sp_reg <= sp_reg + 1'b1;
                stras_pkg::OP_POP:    sp_reg <= sp_dec;
                default: ;
            endcase
            if (op == stras_pkg::OP_OUT) out_valid_reg <= 1'b1;
            else if (m_ready)            out_valid_reg <= 1'b0;
        end
    end

    // walk payload registers
    always_ff @(posedge aclk) begin
        case (op)
            stras_pkg::OP_START: begin
                kind_reg     <= stras_pkg::req_t'(s_req_type);
                a_reg        <= AW'(s_range_low);
                b_reg        <= AW'(s_range_high);
                v_reg        <= s_value;
                cur_node_reg <= NODE_W'(1);
                cur_lo_reg   <= IDX_W'(1);
                cur_hi_reg   <= n;
                acc_reg      <= '0;
            end
            stras_pkg::OP_ACC: acc_reg <= acc_reg + rd_reg.sum;
            stras_pkg::OP_AP_SELF: begin
                ap_tgt_reg <= cur_node_reg;
                ap_add_reg <= v_reg;
                ap_len_reg <= len_self;
            end
            stras_pkg::OP_PUSH_WR: pend_reg <= rd_reg.pend;
            stras_pkg::OP_AP_LEFT: begin
                ap_tgt_reg <= left_node;
                ap_add_reg <= pend_reg;
                ap_len_reg <= len_left;
            end
            stras_pkg::OP_AP_RIGHT: begin
                ap_tgt_reg <= right_node;
                ap_add_reg <= pend_reg;
                ap_len_reg <= len_right;
            end
            // addend times length in two 32-bit halves
            stras_pkg::OP_MUL0: p0_reg <= PW'(ap_add_reg[31:0]) * PW'(ap_len_reg);
            stras_pkg::OP_MUL1: p1_reg <= PW'(ap_add_reg[63:32]) * PW'(ap_len_reg);
            stras_pkg::OP_PSUM: prod_reg <= DW'(p0_reg) + {p1_reg[31:0], 32'd0};
            stras_pkg::OP_RD_RIGHT: lsum_reg <= rd_reg.sum;
            stras_pkg::OP_PUSH_L: begin
                stk_node[push_idx] <= cur_node_reg;
                stk_lo[push_idx]   <= cur_lo_reg;
                stk_hi[push_idx]   <= cur_hi_reg;
                stk_left[push_idx] <= 1'b1;
                cur_node_reg       <= left_node;
                cur_hi_reg         <= mid;
            end
            stras_pkg::OP_PUSH_R: begin
                stk_node[push_idx] <= cur_node_reg;
                stk_lo[push_idx]   <= cur_lo_reg;
                stk_hi[push_idx]   <= cur_hi_reg;
                stk_left[push_idx] <= 1'b0;
                cur_node_reg       <= right_node;
                cur_lo_reg         <= mid + 1'b1;
            end
            stras_pkg::OP_POP: begin
                cur_node_reg <= stk_node[top_idx];
                cur_lo_reg   <= stk_lo[top_idx];
                cur_hi_reg   <= stk_hi[top_idx];
            end
            stras_pkg::OP_OUT: out_sum_reg <= acc_reg;
            default: ;
        endcase
    end

    assign m_valid     = out_valid_reg;
    assign m_range_sum = out_sum_reg;

endmodule

// File: rtl/segment_tree_range_add_sum.sv
// Segment tree with lazy pending adds: range add and range sum over up to
// MAX_ELEMENTS signed 64-bit elements, indices 1..element_count.
// Channels: s_* request channel (valid/ready): req_type 0 load element,
// 1 build tree, 2 range add, 3 range sum query. m_* result channel
// (valid/ready) carries one range_sum per query; other requests give none.
// cfg_wr_en/cfg_wr_data write element_count (reset 1024) while idle.
// One request at a time. Add and query walk the tree from the root and push
// a partly covered node's pending add to its children on the way down; about
// 4*log2(n) nodes are visited per request. A build visits all 2n-1 nodes.
// The single-port node memory sets the step rate.
// Reset: a clearing pass over all 4*MAX_ELEMENTS node addresses zeroes the
// node and element memories with s_ready low. A finished sum sits in the
// output register; the block accepts further requests while it waits, and
// a later query holds at its end until the earlier result has been taken.
// Depends on stras_pkg, stras_ctrl and stras_datapath.
module segment_tree_range_add_sum #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [stras_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic [stras_pkg::CNT_W-1:0]        s_range_low,
    input  logic [stras_pkg::CNT_W-1:0]        s_range_high,
    input  logic signed [stras_pkg::DATA_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [stras_pkg::DATA_W-1:0] m_range_sum
);

    stras_pkg::dp_op_t     op;
    stras_pkg::dp_status_t st;

    // sequencer
    stras_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .op      (op)
    );

    // memories and arithmetic
    stras_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .st           (st),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_req_type   (s_req_type),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .s_value      (s_value),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_range_sum  (m_range_sum)
    );

    // a transaction occupies the engine: ready is low in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accepting a request");

    // reset always starts the clearing pass
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request channel ready during memory clear");

    // results are only produced at the end of a walk
    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while engine was idle");

endmodule

// File: test/segment_tree_range_add_sum_tb.sv
// Self-checking testbench for segment_tree_range_add_sum: random and directed
// load/build/add/query traffic against an in-bench lazy segment tree predictor.
// Depends on stras_pkg and the segment_tree_range_add_sum RTL.
module segment_tree_range_add_sum_tb;

    localparam int MAXN = 1024;
    localparam int DW   = stras_pkg::DATA_W;
    localparam int CW   = stras_pkg::CNT_W;

    // pending stimulus entries: a request, a count write, or a drain pause
    typedef enum logic [1:0] { ENT_REQ, ENT_CFG, ENT_PAUSE } entry_kind_t;
    typedef struct {
        entry_kind_t       tag;
        stras_pkg::req_t   kind;
        logic [CW-1:0]     lo;
        logic [CW-1:0]     hi;
        logic [DW-1:0]     val;
    } entry_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CW-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [CW-1:0] s_range_low = '0;
    logic [CW-1:0] s_range_high = '0;
    logic signed [DW-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DW-1:0] m_range_sum;

    segment_tree_range_add_sum #(.MAX_ELEMENTS(MAXN)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_range_low(s_range_low),
        .s_range_high(s_range_high), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_range_sum(m_range_sum)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [CW-1:0] model_count = stras_pkg::CNT_RESET;
    logic [DW-1:0] model_elem [MAXN];
    logic [DW-1:0] model_sum  [4*MAXN];
    logic [DW-1:0] model_pend [4*MAXN];

    entry_t pending[$];
    logic [DW-1:0] sums_due[$];
    int errors = 0;
    int reqs_sent = 0;
    int sums_checked = 0;
    bit drv_nogap = 1'b0;
    bit mon_nogap = 1'b0;

    function automatic void tree_apply(int k, int lo, int hi, logic [DW-1:0] a);
        model_pend[k] += a;
        model_sum[k]  += a * DW'(hi - lo + 1);
    endfunction

    function automatic void tree_push(int k, int lo, int hi);
        int mid;
        if (model_pend[k] == 0) return;
        mid = (lo + hi) >> 1;
        tree_apply(2*k, lo, mid, model_pend[k]);
        tree_apply(2*k+1, mid+1, hi, model_pend[k]);
        model_pend[k] = '0;
    endfunction

    function automatic void tree_build(int k, int lo, int hi);
        int mid;
        model_pend[k] = '0;
        if (lo == hi) begin
            model_sum[k] = model_elem[lo-1];
            return;
        end
        mid = (lo + hi) >> 1;
        tree_build(2*k, lo, mid);
        tree_build(2*k+1, mid+1, hi);
        model_sum[k] = model_sum[2*k] + model_sum[2*k+1];
    endfunction

    function automatic void tree_add(int k, int lo, int hi, int a, int b,
                                     logic [DW-1:0] v);
        int mid;
        if (a <= lo && hi <= b) begin
            tree_apply(k, lo, hi, v);
            return;
        end
        tree_push(k, lo, hi);
        mid = (lo + hi) >> 1;
        if (a <= mid) tree_add(2*k, lo, mid, a, b, v);
        if (b > mid) tree_add(2*k+1, mid+1, hi, a, b, v);
        model_sum[k] = model_sum[2*k] + model_sum[2*k+1];
    endfunction

    function automatic logic [DW-1:0] tree_sum(int k, int lo, int hi, int a, int b);
        int mid;
        logic [DW-1:0] acc;
        acc = '0;
        if (a <= lo && hi <= b) return model_sum[k];
        tree_push(k, lo, hi);
        mid = (lo + hi) >> 1;
        if (a <= mid) acc += tree_sum(2*k, lo, mid, a, b);
        if (b > mid) acc += tree_sum(2*k+1, mid+1, hi, a, b);
        return acc;
    endfunction

    // apply one accepted request to the predictor, queue a sum for queries
    function automatic void predict_request(entry_t e);
        int n;
        int a;
        int b;
        bit ok;
        n = (model_count > MAXN) ? MAXN : int'(model_count);
        a = int'(e.lo);
        b = int'(e.hi);
        ok = (n >= 1 && a >= 1 && a <= b && b <= n);
        case (e.kind)
            stras_pkg::REQ_LOAD: begin
                if (a >= 1 && a <= n) model_elem[a-1] = e.val;
            end
            stras_pkg::REQ_BUILD: begin
                if (n >= 1) tree_build(1, 1, n);
            end
            stras_pkg::REQ_ADD: begin
                if (ok) tree_add(1, 1, n, a, b, e.val);
            end
            default: begin
                sums_due.push_back(ok ? tree_sum(1, 1, n, a, b) : '0);
            end
        endcase
    endfunction

    function automatic void queue_req(stras_pkg::req_t kind, int lo, int hi,
                                      logic [DW-1:0] val);
        entry_t e;
        e.tag = ENT_REQ;
        e.kind = kind;
        e.lo = CW'(lo);
        e.hi = CW'(hi);
        e.val = val;
        pending.push_back(e);
    endfunction

    function automatic void queue_ctl(entry_kind_t tag, int cnt);
        entry_t e;
        e.tag = tag;
        e.kind = stras_pkg::REQ_LOAD;
        e.lo = '0;
        e.hi = '0;
        e.val = DW'(cnt);
        pending.push_back(e);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    function automatic logic [DW-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return {1'b1, {(DW-1){1'b0}}};
        if (r == 1) return {1'b0, {(DW-1){1'b1}}};
        if (r < 5) return DW'($signed($urandom_range(0, 2000)) - 1000);
        return {$urandom, $urandom};
    endfunction

    // sender: presents queued requests, performs count writes and drain pauses
    always @(posedge aclk) begin : drive
        int gap;
        int settle;
        bit hold;
        bit v_next;
        bit w_next;
        entry_t e;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_wr_en <= 1'b0;
            gap = 0;
            settle = 0;
        end else begin
            v_next = s_valid;
            w_next = 1'b0;
            if (s_valid && s_ready) begin
                predict_request(pending.pop_front());
                reqs_sent++;
                v_next = 1'b0;
            end
            hold = s_valid && !s_ready;
            if (!hold) begin
                v_next = 1'b0;
                if (gap > 0) begin
                    gap--;
                end else if (pending.size() > 0) begin
                    e = pending[0];
                    if (e.tag == ENT_REQ) begin
                        v_next = 1'b1;
                        s_req_type <= e.kind;
                        s_range_low <= e.lo;
                        s_range_high <= e.hi;
                        s_value <= e.val;
                        gap = drv_nogap ? 0 : pick_gap();
                    end else if (sums_due.size() == 0) begin
                        // idle check: let the block finish before a count write
                        if (settle < 40) begin
                            settle++;
                        end else begin
                            settle = 0;
                            if (e.tag == ENT_CFG) begin
                                w_next = 1'b1;
                                cfg_wr_data <= CW'(e.val);
                                model_count = CW'(e.val);
                                drv_nogap = ($urandom_range(0, 3) == 0);
                            end
                            void'(pending.pop_front());
                        end
                    end
                end
            end
            s_valid <= v_next;
            cfg_wr_en <= w_next;
        end
    end

    // receiver: random stalls plus one long hold-off, compares each sum
    always @(posedge aclk) begin : monitor
        int stall;
        bit r_next;
        logic [DW-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sums_due.size() == 0) begin
                    $error("unexpected range_sum %0d", m_range_sum);
                    errors++;
                end else begin
                    want = sums_due.pop_front();
                    if (m_range_sum !== want) begin
                        $error("range_sum expected %0d actual %0d", $signed(want),
                               m_range_sum);
                        errors++;
                    end
                end
                sums_checked++;
                // long hold-off so the block backs up and stalls its input
                if (sums_checked == 150) stall = 4000;
                else if (sums_checked % 97 == 0) mon_nogap = !mon_nogap;
                else if (!mon_nogap) stall = pick_gap();
            end
            if (stall > 0) begin
                stall--;
                r_next = 1'b0;
            end else begin
                r_next = mon_nogap ? 1'b1 : ($urandom_range(0, 9) != 0);
            end
            m_ready <= r_next;
        end
    end

    // stimulus
    initial begin : stimulus
        int counts [10];
        int n;
        int lo;
        int hi;
        int r;
        int lim;
        stras_pkg::req_t k;
        logic [DW-1:0] vmin;
        logic [DW-1:0] vmax;
        counts = '{1, 2, 3, 5, 16, 100, 0, 2047, 37, 1024};
        vmin = {1'b1, {(DW-1){1'b0}}};
        vmax = {1'b0, {(DW-1){1'b1}}};
        for (int i = 0; i < MAXN; i++) model_elem[i] = '0;
        for (int i = 0; i < 4*MAXN; i++) begin
            model_sum[i] = '0;
            model_pend[i] = '0;
        end

        // directed: extremes, ignored loads, bad ranges, stale store, rebuild
        queue_req(stras_pkg::REQ_QUERY, 1, 1024, '0);
        queue_req(stras_pkg::REQ_LOAD, 1, 0, vmin);
        queue_req(stras_pkg::REQ_LOAD, 1024, 0, vmax);
        queue_req(stras_pkg::REQ_LOAD, 0, 0, 64'd5);
        queue_req(stras_pkg::REQ_LOAD, 1025, 0, 64'd7);
        queue_req(stras_pkg::REQ_LOAD, 2047, 2047, '1);
        queue_req(stras_pkg::REQ_LOAD, 512, 0, '1);
        queue_req(stras_pkg::REQ_BUILD, 0, 0, '0);
        queue_req(stras_pkg::REQ_QUERY, 1, 1024, '0);
        queue_req(stras_pkg::REQ_QUERY, 1, 1, '0);
        queue_req(stras_pkg::REQ_QUERY, 1024, 1024, '0);
        queue_req(stras_pkg::REQ_ADD, 1, 1024, vmax);
        queue_req(stras_pkg::REQ_ADD, 5, 3, 64'd9);
        queue_req(stras_pkg::REQ_ADD, 0, 10, 64'd9);
        queue_req(stras_pkg::REQ_QUERY, 3, 2, '0);
        queue_req(stras_pkg::REQ_QUERY, 0, 5, '0);
        queue_req(stras_pkg::REQ_QUERY, 1, 1025, '0);
        queue_req(stras_pkg::REQ_ADD, 1, 512, '1);
        queue_req(stras_pkg::REQ_QUERY, 300, 700, '0);
        queue_req(stras_pkg::REQ_LOAD, 700, 0, 64'd123);
        queue_req(stras_pkg::REQ_QUERY, 700, 700, '0);
        queue_req(stras_pkg::REQ_BUILD, 0, 0, '0);
        queue_req(stras_pkg::REQ_QUERY, 1, 1024, '0);
        queue_req(stras_pkg::REQ_QUERY, 2047, 2047, '0);

        // random phases, each under a new element count
        for (int p = 0; p < 10; p++) begin
            queue_ctl(ENT_CFG, counts[p]);
            n = (counts[p] > MAXN) ? MAXN : counts[p];
            lim = (n < 1) ? 1 : n;
            for (int i = 0; i < 185; i++) begin
                if (p == 3 && i == 90) queue_ctl(ENT_PAUSE, 0);
                r = $urandom_range(0, 99);
                if (r < (n > 200 ? 1 : 8)) k = stras_pkg::REQ_BUILD;
                else if (r < 40) k = stras_pkg::REQ_LOAD;
                else if (r < 68) k = stras_pkg::REQ_ADD;
                else k = stras_pkg::REQ_QUERY;
                if ($urandom_range(0, 99) < 85) begin
                    lo = $urandom_range(1, lim);
                    hi = $urandom_range(lo, lim);
                end else begin
                    lo = $urandom_range(0, 2047);
                    hi = $urandom_range(0, 2047);
                end
                queue_req(k, lo, hi, rand_value());
            end
            // trailing query marks the end of the phase's work
            queue_req(stras_pkg::REQ_QUERY, 1, lim, '0);
        end
        queue_ctl(ENT_CFG, 1024);
        queue_req(stras_pkg::REQ_QUERY, 1, 1024, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending.size() == 0 && !s_valid && sums_due.size() == 0);
        repeat (100) @(posedge aclk);
        $display("covered %0d requests and %0d checked sums over 10 element counts",
                 reqs_sent, sums_checked);
        $display("counts included 0, 1, 1024 and 2047, stale layouts and rebuilds");
        if (errors == 0 && sums_due.size() == 0) begin
            $display("segment_tree_range_add_sum regression: pass");
        end else begin
            $display("segment_tree_range_add_sum regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #240000000;
        $display("segment_tree_range_add_sum regression: fail");
        $finish;
    end

endmodule
